// ===== design/mcd_pkg.sv =====
// shared types and codes for the manchester symbol decoder
`default_nettype none
package mcd_pkg;

	// classified timing symbol codes
	localparam logic [2:0] SYM_START_PAUSE = 3'd0;
	localparam logic [2:0] SYM_SHORT_PAUSE = 3'd1;
	localparam logic [2:0] SYM_LONG_PAUSE  = 3'd2;
	localparam logic [2:0] SYM_SHORT_PULSE = 3'd3;
	localparam logic [2:0] SYM_LONG_PULSE  = 3'd4;

	// end of packet status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_HEADER = 2'd1;
	localparam logic [1:0] ST_BAD_SYMBOL = 2'd2;
	localparam logic [1:0] ST_TOO_SHORT  = 2'd3;

	// configuration register indexes
	localparam logic CFG_MIN_LENGTH       = 1'b0;
	localparam logic CFG_START_WITH_PULSE = 1'b1;

	// reset values of the configuration registers
	localparam logic [7:0] MIN_LENGTH_RST = 8'd10;
	localparam logic       START_PULSE_RST = 1'b1;

	// saturation limit of the symbol counter
	localparam logic [7:0] COUNT_MAX = 8'd255;

	// manchester half-bit phase
	typedef enum logic [3:0] {
		PH_START_PULSE = 4'b0001,
		PH_START_PAUSE = 4'b0010,
		PH_MID_PULSE   = 4'b0100,
		PH_MID_PAUSE   = 4'b1000
	} phase_t;

	// what one symbol produces
	typedef struct packed {
		logic       has_bit;
		logic       bit_val;
		logic       has_status;
		logic [1:0] status;
	} step_t;

	// one result item
	typedef struct packed {
		logic       is_status;
		logic       bit_res;
		logic [1:0] status;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

// ===== design/manchester_symbol_decoder.sv =====
// top level of the manchester symbol decoder
//
// Input stream: one classified timing symbol per item (s_tdata[2:0]),
// s_tlast marks the final symbol of a packet. Output stream: data bits and
// one end of packet status per packet; m_tuser is 1 on a status item,
// m_tlast marks the final result caused by one input symbol.
// Symbols are taken into an input register, decoded by short logic and
// written into a four-entry result queue; the first result of an item
// shows on the output once the item has passed the input register and
// been written into the queue. One symbol per cycle is sustained while
// each symbol yields at most one result and the receiver takes every
// result; a symbol that yields a bit and a status gives two results,
// which leave one by one through the single output port of the queue.
// Configuration writes go through cfg_we/cfg_index/cfg_data; index 0 is
// min_length, index 1 is start_with_pulse (taken at the next header).
// Reset clears the packet state, empties the queue and loads
// min_length 10 and start_with_pulse 1. When the receiver stalls the queue
// fills, the input register holds its symbol and s_tready drops; nothing
// is lost.
`default_nettype none
module manchester_symbol_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input symbols
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [2:0] symbol, [7:3] zero
	input  wire logic       s_tlast,   // last_symbol
	// results
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [0] bit_res, [2:1] status, [7:3] zero
	output logic            m_tuser,   // is_status
	output logic            m_tlast,   // last
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int QDEPTH = 4;

	logic             vld_s1;
	logic [2:0]       symbol_s1;
	logic             last_s1;
	logic [7:0]       min_length_q;
	logic             start_pulse_q;
	mcd_pkg::step_t   step_res;
	mcd_pkg::res_t    queue_q [QDEPTH];
	logic [1:0]       wr_ptr_q;
	logic [1:0]       rd_ptr_q;
	logic [2:0]       count_q;
	logic             pop;
	logic             adv;
	logic [2:0]       count_left;
	logic [1:0]       n_push;
	mcd_pkg::res_t    res0;
	mcd_pkg::res_t    res1;
	mcd_pkg::res_t    head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q  <= mcd_pkg::MIN_LENGTH_RST;
			start_pulse_q <= mcd_pkg::START_PULSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcd_pkg::CFG_MIN_LENGTH:       min_length_q  <= cfg_data;
				mcd_pkg::CFG_START_WITH_PULSE: start_pulse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// queue room: the item in the input register moves on only if two
	// results fit after this cycle's pop
	assign pop        = m_tvalid && m_tready;
	assign count_left = count_q - {2'b00, pop};
	assign adv        = vld_s1 && (count_left <= 3'(QDEPTH - 2));
	assign s_tready   = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			symbol_s1 <= s_tdata[2:0];
			last_s1   <= s_tlast;
		end
	end

	mcd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (adv),
		.symbol           (symbol_s1),
		.last_symbol      (last_s1),
		.min_length       (min_length_q),
		.start_with_pulse (start_pulse_q),
		.res              (step_res)
	);

	// results of one symbol in output order
	always_comb begin
		res0.is_status = !step_res.has_bit;
		res0.bit_res   = step_res.has_bit && step_res.bit_val;
		res0.status    = step_res.has_bit ? mcd_pkg::ST_OK : step_res.status;
		res0.last      = !(step_res.has_bit && step_res.has_status);
		res1.is_status = 1'b1;
		res1.bit_res   = 1'b0;
		res1.status    = step_res.status;
		res1.last      = 1'b1;
		n_push         = 2'd0;
		if (adv) begin
			n_push = {1'b0, step_res.has_bit} + {1'b0, step_res.has_status};
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_left + {1'b0, n_push};
		end
	end

	// output port
	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = (count_q != 3'd0);
	assign m_tdata  = {5'd0, head.status, head.bit_res};
	assign m_tuser  = head.is_status;
	assign m_tlast  = head.last;

endmodule
`default_nettype wire

// ===== design/mcd_core.sv =====
// packet state and manchester decode for one symbol
`default_nettype none
module mcd_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [2:0]      symbol,
	input  wire logic            last_symbol,
	input  wire logic [7:0]      min_length,
	input  wire logic            start_with_pulse,
	output mcd_pkg::step_t       res
);

	mcd_pkg::phase_t phase_q, phase_d;
	logic            in_packet_q, in_packet_d;
	logic [1:0]      error_q, error_d;
	logic [7:0]      count_q, count_d;
	logic            bit_ok;
	logic            bit_val;
	logic            sym_ok;

	// next state and results of the symbol in the input register
	always_comb begin
		phase_d     = phase_q;
		in_packet_d = in_packet_q;
		error_d     = error_q;
		count_d     = count_q;
		bit_ok      = 1'b0;
		bit_val     = 1'b0;
		sym_ok      = 1'b0;
		if (!in_packet_q) begin
			in_packet_d = 1'b1;
			count_d     = 8'd1;
			error_d     = (symbol == mcd_pkg::SYM_START_PAUSE) ?
				mcd_pkg::ST_OK : mcd_pkg::ST_BAD_HEADER;
			phase_d     = start_with_pulse ? mcd_pkg::PH_START_PULSE :
				mcd_pkg::PH_START_PAUSE;
		end else begin
			if (count_q != mcd_pkg::COUNT_MAX) begin
				count_d = count_q + 8'd1;
			end
			if (error_q == mcd_pkg::ST_OK) begin
				unique case (phase_q)
					mcd_pkg::PH_START_PULSE: begin
						if (symbol == mcd_pkg::SYM_SHORT_PULSE) begin
							sym_ok  = 1'b1;
							bit_ok  = 1'b1;
							bit_val = 1'b1;
							phase_d = mcd_pkg::PH_MID_PAUSE;
						end
					end
					mcd_pkg::PH_START_PAUSE: begin
						if (symbol == mcd_pkg::SYM_SHORT_PAUSE) begin
							sym_ok  = 1'b1;
							bit_ok  = 1'b1;
							phase_d = mcd_pkg::PH_MID_PULSE;
						end
					end
					mcd_pkg::PH_MID_PULSE: begin
						if (symbol == mcd_pkg::SYM_SHORT_PULSE) begin
							sym_ok  = 1'b1;
							phase_d = mcd_pkg::PH_START_PAUSE;
						end else if (symbol == mcd_pkg::SYM_LONG_PULSE) begin
							sym_ok  = 1'b1;
							bit_ok  = 1'b1;
							bit_val = 1'b1;
							phase_d = mcd_pkg::PH_MID_PAUSE;
						end
					end
					default: begin
						if (symbol == mcd_pkg::SYM_SHORT_PAUSE) begin
							sym_ok  = 1'b1;
							phase_d = mcd_pkg::PH_START_PULSE;
						end else if (symbol == mcd_pkg::SYM_LONG_PAUSE) begin
							sym_ok  = 1'b1;
							bit_ok  = 1'b1;
							phase_d = mcd_pkg::PH_MID_PULSE;
						end
					end
				endcase
				if (!sym_ok) begin
					error_d = mcd_pkg::ST_BAD_SYMBOL;
				end
			end
		end

		res.has_bit    = bit_ok;
		res.bit_val    = bit_val;
		res.has_status = last_symbol;
		res.status     = (count_d < min_length) ? mcd_pkg::ST_TOO_SHORT : error_d;

		// last symbol closes the packet
		if (last_symbol) begin
			in_packet_d = 1'b0;
			error_d     = mcd_pkg::ST_OK;
			count_d     = 8'd0;
			phase_d     = mcd_pkg::PH_START_PULSE;
		end
	end

	// packet state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mcd_pkg::PH_START_PULSE;
			in_packet_q <= 1'b0;
			error_q     <= mcd_pkg::ST_OK;
			count_q     <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			in_packet_q <= in_packet_d;
			error_q     <= error_d;
			count_q     <= count_d;
		end
	end

endmodule
`default_nettype wire
